### rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication check, held off during reset.
`define ASSERT_CLK(label, clk_sig, rst_sig, prop, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) prop) else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(label, clk_sig, rst_sig, cond, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) !(cond)) else $error(msg);

`endif

### rtl/sstd_pkg.sv
// Package: types and constants of the synchronous tape detector.
package sstd_pkg;

  // Default configuration of the lane array
  localparam int CHANNELS_DEF    = 4;
  localparam int SAMPLE_BITS_DEF = 10;

  // Fixed field widths
  localparam int THRESH_BITS   = 10;
  localparam int OUT_BITS      = 4;
  localparam int SAMPLE_FIELDS = 4;

  // Threshold reset values
  localparam logic [THRESH_BITS-1:0] HIGH_THRESH_RST = THRESH_BITS'(150);
  localparam logic [THRESH_BITS-1:0] LOW_THRESH_RST  = THRESH_BITS'(100);

  // Register index, taken from paddr bit 2
  typedef enum logic [0:0] {
    REG_HIGH_THRESH = 1'b0,
    REG_LOW_THRESH  = 1'b1
  } reg_idx_t;

  // One result item
  typedef struct packed {
    logic [OUT_BITS-1:0] emitter_drive;
    logic [OUT_BITS-1:0] tape_flags;
    logic [OUT_BITS-1:0] change_flags;
    logic                evaluated;
  } result_t;

endpackage

### rtl/sync_sampled_tape_detector.sv
// Top level of the synchronous sampled tape detector.
`include "assert_macros.svh"

// Takes one item per clock while in_ready is high and registers its result.
// All channel lanes compare in parallel; the two-entry output stage (output
// register and skid entry) keeps the input open while one result waits to
// be taken. A timeout item in the lit phase stores the samples and darkens
// the emitters; the next timeout item takes the dark samples, evaluates
// every channel's hysteresis compare and lights the emitters again. Other
// items leave all state unchanged. Thresholds are at APB byte addresses 0
// (high) and 4 (low); the user must write them only while idle (unchecked).
module sync_sampled_tape_detector
  import sstd_pkg::*;
#(
  parameter int CHANNELS    = CHANNELS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  // input channel
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   func,
  input  logic [SAMPLE_BITS-1:0] sample0,
  input  logic [SAMPLE_BITS-1:0] sample1,
  input  logic [SAMPLE_BITS-1:0] sample2,
  input  logic [SAMPLE_BITS-1:0] sample3,
  // output channel
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [OUT_BITS-1:0]    emitter_drive,
  output logic [OUT_BITS-1:0]    tape_flags,
  output logic [OUT_BITS-1:0]    change_flags,
  output logic                   evaluated,
  // configuration port
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [2:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  logic [THRESH_BITS-1:0] high_thresh;
  logic [THRESH_BITS-1:0] low_thresh;
  logic                   lit_phase;
  logic                   lit_phase_next;
  logic                   accept;
  logic                   tick;
  logic                   load;
  logic                   eval;
  logic                   cfg_wr;
  reg_idx_t               reg_idx;
  logic [SAMPLE_BITS-1:0] sample_in [SAMPLE_FIELDS];
  logic [CHANNELS-1:0]    tape_vec;
  logic [CHANNELS-1:0]    change_vec;
  result_t                result;

  // Configuration registers
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      high_thresh <= HIGH_THRESH_RST;
      low_thresh  <= LOW_THRESH_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_HIGH_THRESH: high_thresh <= pwdata[THRESH_BITS-1:0];
        REG_LOW_THRESH:  low_thresh  <= pwdata[THRESH_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_HIGH_THRESH: prdata = 32'(high_thresh);
      REG_LOW_THRESH:  prdata = 32'(low_thresh);
      default:         prdata = '0;
    endcase
  end

  // Phase control
  assign accept = in_valid && in_ready;
  assign tick   = accept && func;
  assign load   = tick && lit_phase;
  assign eval   = tick && !lit_phase;
  assign lit_phase_next = tick ? !lit_phase : lit_phase;

  always_ff @(posedge clk) begin
    if (rst) begin
      lit_phase <= 1'b1;
    end else begin
      lit_phase <= lit_phase_next;
    end
  end

  // Lanes
  assign sample_in[0] = sample0;
  assign sample_in[1] = sample1;
  assign sample_in[2] = sample2;
  assign sample_in[3] = sample3;

  for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
    logic [SAMPLE_BITS-1:0] lane_sample;
    if (i < SAMPLE_FIELDS) begin : g_field
      assign lane_sample = sample_in[i];
    end else begin : g_zero
      assign lane_sample = '0;
    end

    sstd_lane #(
      .SAMPLE_BITS(SAMPLE_BITS)
    ) u_lane (
      .clk        (clk),
      .rst        (rst),
      .load       (load),
      .eval       (eval),
      .sample     (lane_sample),
      .high_thresh(high_thresh),
      .low_thresh (low_thresh),
      .tape_next  (tape_vec[i]),
      .change     (change_vec[i])
    );
  end

  // Merge and output stage
  sstd_merge #(
    .CHANNELS(CHANNELS)
  ) u_merge (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .lit_next  (lit_phase_next),
    .evaluated (eval),
    .tape_vec  (tape_vec),
    .change_vec(change_vec),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .result    (result)
  );

  assign emitter_drive = result.emitter_drive;
  assign tape_flags    = result.tape_flags;
  assign change_flags  = result.change_flags;
  assign evaluated     = result.evaluated;

  // Checks
  `ASSERT_CLK(a_phase_flip, clk, rst, tick |=> (lit_phase != $past(lit_phase)), "phase did not flip on timeout")
  `ASSERT_CLK(a_change_needs_eval, clk, rst, (out_valid && (change_flags != '0)) |-> evaluated, "change flagged outside evaluation")
  `ASSERT_CLK(a_eval_relights, clk, rst, (out_valid && evaluated) |-> (emitter_drive == result.emitter_drive) && (result.emitter_drive[0] == 1'b1), "emitters not lit after evaluation")
  `ASSERT_NEVER(a_stall_without_result, clk, rst, !in_ready && !out_valid, "input stalled with no result pending")

endmodule

### rtl/sstd_lane.sv
// One detector lane: stored lit sample, lit-minus-dark difference, hysteresis.
module sstd_lane
  import sstd_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load,
  input  logic                   eval,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic [THRESH_BITS-1:0] high_thresh,
  input  logic [THRESH_BITS-1:0] low_thresh,
  output logic                   tape_next,
  output logic                   change
);

  localparam int MAG_W = (SAMPLE_BITS > THRESH_BITS) ? SAMPLE_BITS : THRESH_BITS;
  localparam int CMP_W = MAG_W + 1;

  logic [SAMPLE_BITS-1:0] lit_sample;
  logic                   on_tape;
  logic signed [CMP_W-1:0] diff;
  logic signed [CMP_W-1:0] high_s;
  logic signed [CMP_W-1:0] low_s;
  logic                   tape_eval;

  // Exact signed difference and zero-extended thresholds
  assign diff   = $signed(CMP_W'(lit_sample)) - $signed(CMP_W'(sample));
  assign high_s = $signed(CMP_W'(high_thresh));
  assign low_s  = $signed(CMP_W'(low_thresh));

  // Hysteresis: off-tape test wins, inside the band the state holds
  always_comb begin
    tape_eval = on_tape;
    if (diff > high_s) begin
      tape_eval = 1'b0;
    end else if (diff < low_s) begin
      tape_eval = 1'b1;
    end
  end

  assign tape_next = eval ? tape_eval : on_tape;
  assign change    = eval && (tape_eval != on_tape);

  // Lit sample capture, no reset needed
  always_ff @(posedge clk) begin
    if (load) begin
      lit_sample <= sample;
    end
  end

  // Tape state
  always_ff @(posedge clk) begin
    if (rst) begin
      on_tape <= 1'b0;
    end else if (eval) begin
      on_tape <= tape_eval;
    end
  end

endmodule

### rtl/sstd_merge.sv
// Merge stage: folds lane results into one item, output register plus skid entry.
module sstd_merge
  import sstd_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic                lit_next,
  input  logic                evaluated,
  input  logic [CHANNELS-1:0] tape_vec,
  input  logic [CHANNELS-1:0] change_vec,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output result_t             result
);

  result_t res;
  result_t skid;
  logic    skid_valid;
  logic    out_take;

  // Map the lane vectors onto the fixed-width output fields
  for (genvar b = 0; b < OUT_BITS; b++) begin : g_bit
    if (b < CHANNELS) begin : g_lane
      assign res.emitter_drive[b] = lit_next;
      assign res.tape_flags[b]    = tape_vec[b];
      assign res.change_flags[b]  = change_vec[b];
    end else begin : g_pad
      assign res.emitter_drive[b] = 1'b0;
      assign res.tape_flags[b]    = 1'b0;
      assign res.change_flags[b]  = 1'b0;
    end
  end
  assign res.evaluated = evaluated;

  assign out_take = out_valid && out_ready;
  assign in_ready = !skid_valid;

  // Valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_take) begin
        skid_valid <= 1'b0;
      end
    end else if (accept) begin
      if (out_valid && !out_take) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_take) begin
        result <= skid;
      end
    end else if (accept) begin
      if (out_valid && !out_take) begin
        skid <= res;
      end else begin
        result <= res;
      end
    end
  end

endmodule
